/* design/hla_pkg.sv */
// shared types and defaults for the hsl lightness adjust block
`default_nettype none
package hla_pkg;
  localparam int FRACTION_BITS_DEF = 16;

  // which channel holds the maximum, sets the hue sextant base
  typedef enum logic [1:0] {
    SEXT_RED   = 2'd0,
    SEXT_GREEN = 2'd1,
    SEXT_BLUE  = 2'd2
  } sext_t;

  // per-pixel control that rides beside the data
  typedef struct packed {
    logic  cmd;
    logic  neg;
    sext_t sext;
    logic  gray;
  } ctl_t;
endpackage
`default_nettype wire

/* design/hsl_lightness_adjust_top.sv */
// hsl lightness adjust: top level
// usage notes
// - input channel s_*: one pixel per transaction; s_tdata carries the packed
//   color and the lightness step, s_tuser selects brighten (0) or darken (1)
// - output channel m_*: one adjusted color per input transaction, same order,
//   alpha byte forced to 0xff
// - the two dividers take one quotient bit per stage, FRACTION_BITS + 1
//   stages each
// - throughput is one pixel per cycle; a new transaction is taken every cycle
//   while the output register is empty or being drained
// - when the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes in place and s_tready drops; nothing is lost or repeated
// - reset (synchronous, active high) clears every stage valid; data registers
//   keep whatever they held
// - FRACTION_BITS sets the internal fixed-point precision (10 to 24)
`default_nettype none
module hsl_lightness_adjust_top #(
  parameter int FRACTION_BITS = hla_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pixel_color [31:0], lightness_step [48:32], zero pad
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // adjusted_color [31:0]
);
  import hla_pkg::*;

  localparam int FB   = FRACTION_BITS;
  localparam int CT_W = $bits(ctl_t);
  localparam int LT_W = 2 * FB + 2;

  // every stage advances together when the output can move
  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  logic          f_valid;
  ctl_t          f_ctl;
  logic [FB:0]   f_lum, f_step, f_dif, f_mag;
  logic [FB+1:0] f_den;

  hla_front #(.FB(FB)) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_tvalid),
    .cmd            (s_tuser),
    .pixel_color    (s_tdata[31:0]),
    .lightness_step (s_tdata[48:32]),
    .out_valid      (f_valid),
    .ctl            (f_ctl),
    .lum            (f_lum),
    .step           (f_step),
    .dif            (f_dif),
    .den            (f_den),
    .mag            (f_mag)
  );

  // saturation divider carries lightness and step alongside
  logic            s_valid;
  logic [FB:0]     s_quo;
  logic [LT_W-1:0] s_tag;

  hla_div #(.FB(FB), .TAG_W(LT_W)) u_div_sat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_dif),
    .den       (f_den),
    .tag_in    ({f_lum, f_step}),
    .out_valid (s_valid),
    .quo       (s_quo),
    .tag_out   (s_tag)
  );

  // hue divider divides by the channel spread and carries the control word
  logic            h_valid;
  logic [FB:0]     h_quo;
  logic [CT_W-1:0] h_tag;

  hla_div #(.FB(FB), .TAG_W(CT_W)) u_div_hue (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_mag),
    .den       ({1'b0, f_dif}),
    .tag_in    (f_ctl),
    .out_valid (h_valid),
    .quo       (h_quo),
    .tag_out   (h_tag)
  );

  hla_recon #(.FB(FB)) u_recon (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid & h_valid),
    .sat       (s_quo),
    .hq        (h_quo),
    .ctl       (ctl_t'(h_tag)),
    .lum       (s_tag[LT_W-1:FB+1]),
    .step      (s_tag[FB:0]),
    .out_valid (m_tvalid),
    .color     (m_tdata)
  );
endmodule
`default_nettype wire

/* design/hla_front.sv */
// rgb to fixed point, min/max, lightness and divider operands
`default_nettype none
module hla_front #(
  parameter int FB = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              cmd,
  input  logic [31:0]       pixel_color,
  input  logic [16:0]       lightness_step,
  output logic              out_valid,
  output hla_pkg::ctl_t     ctl,
  output logic [FB:0]       lum,
  output logic [FB:0]       step,
  output logic [FB:0]       dif,
  output logic [FB+1:0]     den,
  output logic [FB:0]       mag
);
  import hla_pkg::*;

  localparam int QUOT = (1 << FB) / 255;
  localparam int REMD = (1 << FB) % 255;
  localparam logic [FB:0]   HALF = (FB+1)'(1 << (FB - 1));
  localparam logic [FB+1:0] TWO  = (FB+2)'(1 << (FB + 1));

  // floor(c * 2^FB / 255) as c*quot + floor(c*remd/255)
  function automatic logic [FB:0] to_fx(input logic [7:0] c);
    logic [FB:0] hi;
    logic [15:0] y;
    logic [15:0] lo;
    hi = (FB+1)'(c) * (FB+1)'(QUOT);
    y  = 16'(c) * 16'(REMD);
    lo = (y + (y >> 8) + 16'd1) >> 8;
    return hi + (FB+1)'(lo);
  endfunction

  logic [FB:0] step_fx;

  if (FB > 16) begin : g_step_up
    assign step_fx = {lightness_step, {(FB-16){1'b0}}};
  end else if (FB == 16) begin : g_step_eq
    assign step_fx = lightness_step;
  end else begin : g_step_dn
    assign step_fx = lightness_step[16:16-FB];
  end

  // stage a: channel conversion
  logic        a_valid;
  logic        a_cmd;
  logic [FB:0] a_r, a_g, a_b, a_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_cmd  <= cmd;
      a_r    <= to_fx(pixel_color[15:8]);
      a_g    <= to_fx(pixel_color[23:16]);
      a_b    <= to_fx(pixel_color[31:24]);
      a_step <= step_fx;
    end
  end

  // stage b: extremes, lightness, hue difference
  logic [FB:0]   cmax, cmin, hx, hy;
  logic [FB+1:0] sum;
  logic [FB:0]   l_b;
  sext_t         sext;
  logic          neg;

  always_comb begin
    cmax = a_r;
    cmin = a_r;
    if (a_g > cmax) cmax = a_g;
    if (a_b > cmax) cmax = a_b;
    if (a_g < cmin) cmin = a_g;
    if (a_b < cmin) cmin = a_b;
    sum = {1'b0, cmax} + {1'b0, cmin};
    l_b = sum[FB+1:1];
    if (a_r == cmax) begin
      hx = a_g; hy = a_b; sext = SEXT_RED;
    end else if (a_g == cmax) begin
      hx = a_b; hy = a_r; sext = SEXT_GREEN;
    end else begin
      hx = a_r; hy = a_g; sext = SEXT_BLUE;
    end
    neg = hx < hy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
    if (en) begin
      ctl.cmd  <= a_cmd;
      ctl.neg  <= neg;
      ctl.sext <= sext;
      ctl.gray <= cmax == cmin;
      lum      <= l_b;
      step     <= a_step;
      dif      <= cmax - cmin;
      den      <= (l_b < HALF) ? sum : TWO - sum;
      mag      <= neg ? hy - hx : hx - hy;
    end
  end
endmodule
`default_nettype wire

/* design/hla_div.sv */
// pipelined restoring divider, floor(num * 2^FB / den), one quotient bit per stage
`default_nettype none
module hla_div #(
  parameter int FB    = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [FB:0]      num,
  input  logic [FB+1:0]    den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [FB:0]      quo,
  output logic [TAG_W-1:0] tag_out
);
  localparam int NS = FB + 1;

  logic [FB+1:0]    rem_q [0:NS-1];
  logic [FB:0]      quo_q [0:NS-1];
  logic [FB+1:0]    den_q [0:NS-1];
  logic [TAG_W-1:0] tag_q [0:NS-1];
  logic             vld_q [0:NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [FB+2:0]    trial;
    logic [FB+2:0]    diff;
    logic [FB+1:0]    dsr;
    logic [FB:0]      qin;
    logic [TAG_W-1:0] tin;
    logic             vin;
    logic             ge;

    if (j == 0) begin : g_first
      // remainder starts at num >> 1 with num[0] shifted in
      assign trial = {2'b00, num};
      assign dsr   = den;
      assign qin   = '0;
      assign tin   = tag_in;
      assign vin   = in_valid;
    end else begin : g_next
      assign trial = {rem_q[j-1], 1'b0};
      assign dsr   = den_q[j-1];
      assign qin   = quo_q[j-1];
      assign tin   = tag_q[j-1];
      assign vin   = vld_q[j-1];
    end

    assign diff = trial - {1'b0, dsr};
    assign ge   = trial >= {1'b0, dsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vin;
      end
      if (en) begin
        rem_q[j] <= ge ? diff[FB+1:0] : trial[FB+1:0];
        quo_q[j] <= {qin[FB-1:0], ge};
        den_q[j] <= dsr;
        tag_q[j] <= tin;
      end
    end
  end

  assign out_valid = vld_q[NS-1];
  assign quo       = quo_q[NS-1];
  assign tag_out   = tag_q[NS-1];
endmodule
`default_nettype wire

/* design/hla_recon.sv */
// hue assembly, lightness step and hsl to rgb back conversion
`default_nettype none
module hla_recon #(
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [FB:0]   sat,
  input  logic [FB:0]   hq,
  input  hla_pkg::ctl_t ctl,
  input  logic [FB:0]   lum,
  input  logic [FB:0]   step,
  output logic          out_valid,
  output logic [31:0]   color
);
  import hla_pkg::*;

  typedef enum logic [1:0] {
    SEL_LO   = 2'd0,
    SEL_RAMP = 2'd1,
    SEL_HI   = 2'd2
  } csel_t;

  localparam logic CMD_BRIGHTEN = 1'b0;

  localparam logic [FB:0]   ONE   = (FB+1)'(1 << FB);
  localparam logic [FB:0]   HALF  = (FB+1)'(1 << (FB - 1));
  localparam logic [FB+2:0] ONE_H = (FB+3)'(1 << FB);
  localparam logic [FB+2:0] TWO_H = (FB+3)'(2 << FB);
  localparam logic [FB+2:0] THR_H = (FB+3)'(3 << FB);
  localparam logic [FB+2:0] FOU_H = (FB+3)'(4 << FB);
  localparam logic signed [FB+3:0] TWO_S = (FB+4)'(2 << FB);
  localparam logic signed [FB+3:0] FOU_S = (FB+4)'(4 << FB);
  localparam logic signed [FB+3:0] SIX_S = (FB+4)'(6 << FB);

  // stage c: hue in sixths, saturation, adjusted lightness
  logic signed [FB+3:0] hbase, hs, qs;
  logic [FB+1:0]        bsum;
  logic [FB:0]          l_adj;

  always_comb begin
    case (ctl.sext)
      SEXT_RED:   hbase = '0;
      SEXT_GREEN: hbase = TWO_S;
      SEXT_BLUE:  hbase = FOU_S;
      default:    hbase = '0;
    endcase
    qs = $signed({3'b000, hq});
    hs = ctl.neg ? hbase - qs : hbase + qs;
    if (hs < 0) hs = hs + SIX_S;
    bsum = {1'b0, lum} + {1'b0, step};
    if (ctl.cmd == CMD_BRIGHTEN) begin
      l_adj = (bsum > {1'b0, ONE}) ? ONE : bsum[FB:0];
    end else begin
      l_adj = (step >= lum) ? '0 : lum - step;
    end
  end

  logic          c_valid;
  logic [FB+2:0] c_h6;
  logic [FB:0]   c_s, c_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= in_valid;
    end
    if (en) begin
      c_h6 <= ctl.gray ? '0 : hs[FB+2:0];
      c_s  <= ctl.gray ? '0 : sat;
      c_l  <= l_adj;
    end
  end

  // stage d: w2 product, channel positions and regions
  logic          le_half;
  logic [FB+1:0] mb;
  logic [FB+2:0] pos [0:2];
  csel_t         sel_d [0:2];
  logic [FB:0]   t_d [0:2];

  always_comb begin
    le_half = c_l <= HALF;
    mb      = le_half ? {1'b0, ONE} + {1'b0, c_s} : {1'b0, c_s};
    pos[0]  = (c_h6 < FOU_H) ? c_h6 + TWO_H : c_h6 - FOU_H;
    pos[1]  = c_h6;
    pos[2]  = (c_h6 >= TWO_H) ? c_h6 - TWO_H : c_h6 + FOU_H;
    for (int k = 0; k < 3; k++) begin
      if (pos[k] < ONE_H) begin
        sel_d[k] = SEL_RAMP;
        t_d[k]   = pos[k][FB:0];
      end else if (pos[k] < THR_H) begin
        sel_d[k] = SEL_HI;
        t_d[k]   = '0;
      end else if (pos[k] < FOU_H) begin
        sel_d[k] = SEL_RAMP;
        t_d[k]   = (FB+1)'(FOU_H - pos[k]);
      end else begin
        sel_d[k] = SEL_LO;
        t_d[k]   = '0;
      end
    end
  end

  logic            d_valid, d_le;
  logic [2*FB+2:0] d_prod;
  logic [FB:0]     d_l, d_s;
  csel_t           d_sel [0:2];
  logic [FB:0]     d_t [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_le   <= le_half;
      d_prod <= (2*FB+3)'(c_l) * (2*FB+3)'(mb);
      d_l    <= c_l;
      d_s    <= c_s;
      for (int k = 0; k < 3; k++) begin
        d_sel[k] <= sel_d[k];
        d_t[k]   <= t_d[k];
      end
    end
  end

  // stage e: the two hsl helper values
  logic [FB+2:0] ls;
  logic [FB+1:0] w2, w1;

  always_comb begin
    ls = d_prod[2*FB+2:FB];
    w2 = d_le ? ls[FB+1:0] : {1'b0, d_l} + {1'b0, d_s} - ls[FB+1:0];
    w1 = {d_l, 1'b0} - w2;
  end

  logic          e_valid;
  logic [FB+1:0] e_w1, e_w2, e_dw;
  csel_t         e_sel [0:2];
  logic [FB:0]   e_t [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_w1 <= w1;
      e_w2 <= w2;
      e_dw <= w2 - w1;
      for (int k = 0; k < 3; k++) begin
        e_sel[k] <= d_sel[k];
        e_t[k]   <= d_t[k];
      end
    end
  end

  // stage f: ramp products
  logic            f_valid;
  logic [FB+1:0]   f_w1, f_w2;
  logic [2*FB+2:0] f_prod [0:2];
  csel_t           f_sel [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_w1 <= e_w1;
      f_w2 <= e_w2;
      for (int k = 0; k < 3; k++) begin
        f_prod[k] <= (2*FB+3)'(e_dw) * (2*FB+3)'(e_t[k]);
        f_sel[k]  <= e_sel[k];
      end
    end
  end

  // stage g: channel value, clamp, scale to a byte
  logic [FB+1:0] v [0:2];
  logic [FB+9:0] sc [0:2];
  logic [7:0]    ch [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (f_sel[k])
        SEL_RAMP: v[k] = f_w1 + f_prod[k][FB+FB+1:FB];
        SEL_HI:   v[k] = f_w2;
        default:  v[k] = f_w1;
      endcase
      if (v[k] > {1'b0, ONE}) v[k] = {1'b0, ONE};
      sc[k] = ((FB+10)'(v[k]) << 8) - (FB+10)'(v[k]);
      ch[k] = sc[k][FB+7:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_valid;
    end
    if (en) begin
      color <= {ch[2], ch[1], ch[0], 8'hFF};
    end
  end
endmodule
`default_nettype wire

/* design/hla_checker.sv */
// port-level checks for the hsl lightness adjust top level, with bind
`default_nettype none
module hla_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  // stalled result stays presented
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // alpha byte is opaque on every valid result
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] == 8'hFF)
    else $error("alpha byte not 0xff");

  // an empty output register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
endmodule

bind hsl_lightness_adjust_top hla_checker u_hla_checker (.*);
`default_nettype wire
